// ===== rtl/ccest_pkg.sv =====
// ----------------------------------------------------------------------------
// ccest_pkg
// shared types and constants of the coulomb counter current estimator
// ----------------------------------------------------------------------------
package ccest_pkg;

  localparam int INTERVAL_BITS = 16;
  localparam int SCALE_W       = 24;
  localparam int COUNT_W       = 32;
  localparam int EST_W         = SCALE_W + 1;
  localparam int IVL_OUT_W     = 16;
  localparam int IVL_W         = (INTERVAL_BITS > IVL_OUT_W) ? INTERVAL_BITS : IVL_OUT_W;
  localparam int DIV_STEPS     = SCALE_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(339847);
  localparam logic [IVL_OUT_W-1:0] IVL_OUT_MAX = '1;

  localparam int OUT_DATA_RAW_W = COUNT_W + EST_W + IVL_OUT_W;
  localparam int OUT_DATA_W     = ((OUT_DATA_RAW_W + 7) / 8) * 8;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_PULSE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ccest_state_t;

  typedef struct packed {
    logic                     start;
    logic [SCALE_W-1:0]       dividend;
    logic [INTERVAL_BITS-1:0] divisor;
  } ccest_div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] quotient;
  } ccest_div_rsp_t;

endpackage

// ===== rtl/ccest_div.sv =====
// ----------------------------------------------------------------------------
// ccest_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ccest_div import ccest_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ccest_div_req_t req,
  output ccest_div_rsp_t rsp
);

  logic                     busy_r,  busy_nxt;
  logic                     done_r,  done_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [SCALE_W-1:0]       quo_r,   quo_nxt;
  logic [INTERVAL_BITS-1:0] rem_r,   rem_nxt;
  logic [INTERVAL_BITS-1:0] dvs_r,   dvs_nxt;
  logic [INTERVAL_BITS:0]   rem_sh;
  logic [INTERVAL_BITS:0]   diff;

  assign rem_sh = {rem_r, quo_r[SCALE_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // trial subtract; keep the shifted remainder when it goes negative
      if (!diff[INTERVAL_BITS]) begin
        rem_nxt = diff[INTERVAL_BITS-1:0];
        quo_nxt = {quo_r[SCALE_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[INTERVAL_BITS-1:0];
        quo_nxt = {quo_r[SCALE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && cnt_r == '0)
    else $error("divider done without finishing its steps");

  a_start_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/coulomb_counter_current_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// coulomb_counter_current_estimator_unit
// charge count and current estimate from coulomb counter pulses and ms ticks
// ----------------------------------------------------------------------------
// A tick beat (in_tuser = 0) is taken when the block is idle and advances the interval
// counter, which sticks at its maximum. A pulse beat (in_tuser = 1) moves the
// charge count, clears the interval and divides the scale register by the
// interval in a bit-serial divider: 24 steps of one quotient bit per cycle. A
// pulse holds in_tready low through the division and ST_DONE (only ST_DONE
// when the interval was zero and no division is needed), plus any time the
// previous result still sits unread in the output register. Ticks are taken in
// any idle cycle; config writes are taken in any cycle, cfg_ready is always high.
module coulomb_counter_current_estimator_unit import ccest_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] polarity, [7:1] zero
  input  logic [0:0]            in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] charge_count, [56:32] current_estimate, [72:57] interval_ms, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]            out_tuser,  // [0] zero_interval
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SCALE_W-1:0]    cfg_data
);

  ccest_state_t             state_r, state_nxt;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic [COUNT_W-1:0]       total_r, total_nxt;
  logic [INTERVAL_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [INTERVAL_BITS-1:0] ivl_r, ivl_nxt;
  logic                     pol_r, pol_nxt;
  logic                     zero_r, zero_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                     out_zero_r, out_zero_nxt;

  logic                     in_fire;
  logic                     pulse;
  logic                     load_out;
  logic [SCALE_W-1:0]       mag;
  logic [EST_W-1:0]         est;
  logic [IVL_W-1:0]         ivl_ext;
  logic [IVL_OUT_W-1:0]     ivl_out;
  ccest_div_req_t           div_req;
  ccest_div_rsp_t           div_rsp;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign pulse     = in_fire && (in_tuser[0] == KIND_PULSE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign div_req.start    = pulse && (elapsed_r != '0);
  assign div_req.dividend = scale_r;
  assign div_req.divisor  = elapsed_r;

  ccest_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign mag     = zero_r ? scale_r : div_rsp.quotient;
  assign est     = pol_r ? (EST_W'(0) - {1'b0, mag}) : {1'b0, mag};
  assign ivl_ext = IVL_W'(ivl_r);
  // wide counters report the interval clipped to the field
  assign ivl_out = (ivl_ext > IVL_W'(IVL_OUT_MAX)) ? IVL_OUT_MAX : ivl_ext[IVL_OUT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    total_nxt     = total_r;
    elapsed_nxt   = elapsed_r;
    ivl_nxt       = ivl_r;
    pol_nxt       = pol_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_zero_nxt  = out_zero_r;

    if (cfg_valid && cfg_ready) begin
      scale_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == KIND_TICK) begin
            if (elapsed_r != '1) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
          end else begin
            ivl_nxt     = elapsed_r;
            pol_nxt     = in_tdata[0];
            zero_nxt    = (elapsed_r == '0);
            elapsed_nxt = '0;
            total_nxt   = in_tdata[0] ? (total_r + 1'b1) : (total_r - 1'b1);
            state_nxt   = (elapsed_r == '0) ? ST_DONE : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({ivl_out, est, total_r});
          out_zero_nxt  = zero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= SCALE_RESET;
      total_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      total_r     <= total_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ivl_r      <= ivl_nxt;
    pol_r      <= pol_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

`ifndef SYNTHESIS
  a_pulse_clears_interval: assert property (@(posedge clk) disable iff (!rst_n)
    pulse |=> elapsed_r == '0)
    else $error("interval not cleared after pulse");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside division state");

  a_zero_flag_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata[72:57] == '0)
    else $error("zero interval flag with non-zero interval");
`endif

endmodule

// ===== verif/coulomb_counter_current_estimator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coulomb_counter_current_estimator_unit_tb
// self-checking bench: tick and pulse beats go in, every result beat is
// compared field by field with a cycle-free model of the charge count,
// interval counter and K / interval divider kept inside the bench
// ----------------------------------------------------------------------------
module coulomb_counter_current_estimator_unit_tb;
  import ccest_pkg::*;

  localparam logic POL_LOW      = 1'b0;
  localparam logic POL_HIGH     = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   PHASE_ITEMS   = 120;
  localparam int   PHASE_PULSES  = 5;

  typedef struct packed {
    logic signed [COUNT_W-1:0] charge_count;
    logic signed [EST_W-1:0]   current_estimate;
    logic [IVL_OUT_W-1:0]      interval_ms;
    logic                      zero_interval;
  } pulse_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;    // [0] polarity, [7:1] zero
  logic [0:0]            in_tuser = '0;    // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [31:0] charge_count, [56:32] current_estimate, [72:57] interval_ms
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;        // [0] zero_interval
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SCALE_W-1:0]    cfg_data = '0;

  // bench copy of the block state
  logic [SCALE_W-1:0]       scale_k = SCALE_RESET;
  logic [COUNT_W-1:0]       charge_total = '0;
  logic [INTERVAL_BITS-1:0] elapsed_ms = '0;

  pulse_result_t pulse_results_q[$];
  bit            idle_en = 1'b1;
  int            mismatches = 0;

  coulomb_counter_current_estimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // advance the interval counter or account one pulse
  task automatic account_beat(input logic kind, input logic pol);
    pulse_result_t      r;
    logic [SCALE_W-1:0] mag;
    if (kind == KIND_TICK) begin
      if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
    end else begin
      r.zero_interval = (elapsed_ms == '0);
      mag = r.zero_interval ? scale_k : SCALE_W'(scale_k / elapsed_ms);
      charge_total = (pol == POL_HIGH) ? charge_total + 1'b1 : charge_total - 1'b1;
      r.charge_count = charge_total;
      // negative estimate while charging
      r.current_estimate = (pol == POL_HIGH) ? EST_W'(0) - {1'b0, mag} : {1'b0, mag};
      r.interval_ms = (elapsed_ms > IVL_OUT_MAX) ? IVL_OUT_MAX : IVL_OUT_W'(elapsed_ms);
      elapsed_ms = '0;
      pulse_results_q.push_back(r);
    end
  endtask

  // called at a falling edge, returns at a falling edge with tvalid left high
  task automatic send_beat(input logic kind, input logic pol);
    if (idle_en && $urandom_range(99) < 4) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, pol};
    do @(posedge clk); while (!in_tready);
    account_beat(kind, pol);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(KIND_TICK, 1'($urandom));
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (pulse_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    scale_k = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(99) < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(4, 1)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    pulse_result_t got;
    pulse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.charge_count     = out_tdata[COUNT_W-1:0];
      got.current_estimate = out_tdata[COUNT_W +: EST_W];
      got.interval_ms      = out_tdata[COUNT_W+EST_W +: IVL_OUT_W];
      got.zero_interval    = out_tuser[0];
      if (pulse_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing expected: count %0d est %0d ivl %0d zero %0b",
                   got.charge_count, got.current_estimate, got.interval_ms,
                   got.zero_interval);
      end else begin
        want = pulse_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: count %0d/%0d est %0d/%0d ivl %0d/%0d zero %0b/%0b (exp/got)",
                     want.charge_count, got.charge_count,
                     want.current_estimate, got.current_estimate,
                     want.interval_ms, got.interval_ms,
                     want.zero_interval, got.zero_interval);
        end
      end
    end
  end

  task automatic test_default_scale;
    send_beat(KIND_PULSE, POL_LOW);
    send_beat(KIND_PULSE, POL_HIGH);
    send_ticks(1);
    send_beat(KIND_PULSE, POL_HIGH);
    send_ticks(3);
    send_beat(KIND_PULSE, POL_LOW);
    send_beat(KIND_TICK, POL_HIGH);
    send_beat(KIND_TICK, POL_HIGH);
    send_beat(KIND_PULSE, POL_HIGH);
    wait_drained();
  endtask

  task automatic test_scale_extremes;
    write_scale('1);
    send_beat(KIND_PULSE, POL_LOW);
    send_ticks(7);
    send_beat(KIND_PULSE, POL_HIGH);
    wait_drained();
    write_scale(SCALE_W'(1));
    send_ticks(2);
    send_beat(KIND_PULSE, POL_LOW);
    send_beat(KIND_PULSE, POL_HIGH);
    wait_drained();
    // zero scale gives a zero estimate, also on a zero interval
    write_scale('0);
    send_ticks(5);
    send_beat(KIND_PULSE, POL_HIGH);
    send_beat(KIND_PULSE, POL_LOW);
    wait_drained();
  endtask

  task automatic test_long_interval;
    write_scale('1);
    send_ticks(200);
    send_beat(KIND_PULSE, POL_HIGH);
    send_ticks(2);
    send_beat(KIND_PULSE, POL_LOW);
    wait_drained();
  endtask

  task automatic test_random_traffic;
    logic [SCALE_W-1:0] k;
    int items;
    int pulses;
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       k = SCALE_W'($urandom_range(1000, 1));
        1:       k = '1;
        2:       k = SCALE_RESET;
        default: k = SCALE_W'($urandom);
      endcase
      // one phase runs with both sides flat out
      idle_en = (phase != 2);
      write_scale(k);
      items = 0;
      pulses = 0;
      while (items < PHASE_ITEMS || pulses < PHASE_PULSES) begin
        pick = $urandom_range(99);
        if (pick < 30)      pick = 0;
        else if (pick < 88) pick = $urandom_range(12, 1);
        else if (pick < 98) pick = $urandom_range(150, 13);
        else                pick = $urandom_range(800, 151);
        send_ticks(pick);
        send_beat(KIND_PULSE, 1'($urandom));
        items += pick + 1;
        pulses++;
      end
      wait_drained();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_scale();
    test_scale_extremes();
    test_long_interval();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && pulse_results_q.size() == 0)
      $display("coulomb_counter_current_estimator_unit_tb passed");
    else
      $display("coulomb_counter_current_estimator_unit_tb failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("coulomb_counter_current_estimator_unit_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ccest_pkg.sv
rtl/ccest_div.sv
rtl/coulomb_counter_current_estimator_unit.sv
verif/coulomb_counter_current_estimator_unit_tb.sv
